[hw/rtl/dcea_pkg.sv]
// ----------------------------------------------------------------------------
// dcea_pkg
// Shared types and field widths for the depth and color error accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package dcea_pkg;

	localparam int DEPTH_W     = 16;
	localparam int COLOR_W     = 8;
	localparam int DSUM_W      = 36;
	localparam int CSUM_W      = 35;
	localparam int COUNT_W     = 20;
	localparam int SUMSQ_W     = 18;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 96;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SQ   = 4'b0010,
		ST_ROOT = 4'b0100,
		ST_ACC  = 4'b1000
	} state_t;

	// Color channel selector for the shared multiplier.
	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} chan_t;

endpackage

`default_nettype wire

[hw/rtl/depth_color_error_accumulator_top.sv]
// ----------------------------------------------------------------------------
// depth_color_error_accumulator_top
// Masked sum of absolute depth error and Euclidean RGB error over a frame.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: pixel pair, tlast: last pixel
// m_axis    out        m_axis_tvalid/tready       tdata: sums and count, tuser: saturated
// cfg       in         cfg_valid/cfg_ready        cfg_data: measured depth range limit
//
// Each input transaction occupies the block after acceptance: the three
// channel squares on the shared 8x8 multiplier, one channel at a time,
// then the restoring square root at one result bit per cycle, then the
// accumulate state. s_axis_tready is low during that time. The result of a
// frame sits in an output register, so a new pixel is taken while it waits;
// only a following last pixel stalls in the accumulate state until the
// previous result has been taken.
// The asynchronous reset clears the sums, the count, the flag, the output
// valid and restores the range limit to 65535. cfg_ready is always high.

`default_nettype none

module depth_color_error_accumulator_top #(
	parameter int MAX_PIXELS      = 524288,
	parameter int COLOR_FRAC_BITS = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// [15:0] ref_depth, [31:16] meas_depth, [39:32] ref_red, [47:40] ref_green,
	// [55:48] ref_blue, [63:56] meas_red, [71:64] meas_green, [79:72] meas_blue
	input  wire logic [dcea_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  wire logic                                s_axis_tlast,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [35:0] depth_error_sum, [70:36] color_error_sum, [90:71] pixel_count,
	// [95:91] zero
	output logic [dcea_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	// [0] saturated
	output logic                                     m_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	input  wire logic [dcea_pkg::DEPTH_W-1:0]        cfg_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready
);
	import dcea_pkg::*;

	// Square root result bits: the sum of squares fits in 18 bits.
	localparam int RB   = SUMSQ_W / 2 + COLOR_FRAC_BITS;
	localparam int RADW = 2 * RB;
	localparam int SW   = $clog2(RB);
	localparam logic [COUNT_W-1:0] COUNT_CAP =
		(MAX_PIXELS < (2**COUNT_W - 1)) ? COUNT_W'(MAX_PIXELS) : {COUNT_W{1'b1}};

	state_t               state_q;
	chan_t                chan_q;
	logic [SW-1:0]        step_q;
	logic [DEPTH_W-1:0]   max_range_q;

	// Per-pixel working registers.
	logic                 valid_q;
	logic                 last_q;
	logic [DEPTH_W-1:0]   dd_q;
	logic [COLOR_W-1:0]   dr_q, dg_q, db_q;
	logic [SUMSQ_W-1:0]   sumsq_q;
	logic [RADW-1:0]      rad_q;
	logic [RB+1:0]        rem_q;
	logic [RB-1:0]        root_q;

	// Frame accumulators.
	logic [DSUM_W-1:0]    dsum_q;
	logic [CSUM_W-1:0]    csum_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 ovf_q;

	// Output register.
	logic                 out_valid_q;
	logic [DSUM_W-1:0]    out_dsum_q;
	logic [CSUM_W-1:0]    out_csum_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic                 out_sat_q;

	// Input field views.
	logic [DEPTH_W-1:0]   in_rd, in_md;
	logic [COLOR_W-1:0]   in_rr, in_rg, in_rb, in_mr, in_mg, in_mb;
	logic                 in_take;

	assign in_rd = s_axis_tdata[15:0];
	assign in_md = s_axis_tdata[31:16];
	assign in_rr = s_axis_tdata[39:32];
	assign in_rg = s_axis_tdata[47:40];
	assign in_rb = s_axis_tdata[55:48];
	assign in_mr = s_axis_tdata[63:56];
	assign in_mg = s_axis_tdata[71:64];
	assign in_mb = s_axis_tdata[79:72];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	function automatic logic [COLOR_W-1:0] absdiff8(input logic [COLOR_W-1:0] a,
	                                                input logic [COLOR_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Shared multiplier: one channel square per cycle.
	logic [COLOR_W-1:0]   mul_op;
	logic [2*COLOR_W-1:0] mul_prod;
	logic [SUMSQ_W-1:0]   sumsq_next;

	always_comb begin
		case (chan_q)
			CH_RED:   mul_op = dr_q;
			CH_GREEN: mul_op = dg_q;
			CH_BLUE:  mul_op = db_q;
			default:  mul_op = '0;
		endcase
		mul_prod   = mul_op * mul_op;
		sumsq_next = sumsq_q + SUMSQ_W'(mul_prod);
	end

	// One restoring square root step per cycle.
	logic [RB+1:0] rem_sh;
	logic [RB+1:0] trial;
	logic          fits;

	always_comb begin
		rem_sh = {rem_q[RB-1:0], rad_q[RADW-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	// Saturating accumulate of the finished pixel.
	logic [DSUM_W:0]     dsum_add;
	logic [CSUM_W:0]     csum_add;
	logic [DSUM_W-1:0]   dsum_next;
	logic [CSUM_W-1:0]   csum_next;
	logic [COUNT_W-1:0]  count_next;
	logic                ovf_next;
	logic                can_emit;
	logic                emit;

	always_comb begin
		dsum_add   = {1'b0, dsum_q} + (DSUM_W+1)'(dd_q);
		csum_add   = {1'b0, csum_q} + (CSUM_W+1)'(root_q);
		dsum_next  = dsum_q;
		csum_next  = csum_q;
		count_next = count_q;
		ovf_next   = ovf_q;
		if (valid_q) begin
			if (dsum_add[DSUM_W]) begin
				dsum_next = {DSUM_W{1'b1}};
				ovf_next  = 1'b1;
			end else begin
				dsum_next = dsum_add[DSUM_W-1:0];
			end
			if (csum_add[CSUM_W]) begin
				csum_next = {CSUM_W{1'b1}};
				ovf_next  = 1'b1;
			end else begin
				csum_next = csum_add[CSUM_W-1:0];
			end
			if (count_q >= COUNT_CAP) begin
				ovf_next = 1'b1;
			end else begin
				count_next = count_q + COUNT_W'(1);
			end
		end
		// A last pixel may only finish once the output register is free.
		can_emit = !out_valid_q || m_axis_tready;
		emit     = (state_q == ST_ACC) && last_q && can_emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chan_q      <= CH_RED;
			step_q      <= '0;
			max_range_q <= {DEPTH_W{1'b1}};
			dsum_q      <= '0;
			csum_q      <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_range_q <= cfg_data;
			end
			// A new frame result may load in the same cycle the old one is taken.
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						chan_q  <= CH_RED;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					case (chan_q)
						CH_RED:   chan_q <= CH_GREEN;
						CH_GREEN: chan_q <= CH_BLUE;
						default: begin
							step_q  <= SW'(RB - 1);
							state_q <= ST_ROOT;
						end
					endcase
				end
				ST_ROOT: begin
					step_q <= step_q - SW'(1);
					if (step_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (!last_q) begin
						dsum_q  <= dsum_next;
						csum_q  <= csum_next;
						count_q <= count_next;
						ovf_q   <= ovf_next;
						state_q <= ST_IDLE;
					end else if (can_emit) begin
						dsum_q      <= '0;
						csum_q      <= '0;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					valid_q <= (in_rd != '0) && (in_md != '0) && (in_md <= max_range_q);
					last_q  <= s_axis_tlast;
					dd_q    <= (in_md > in_rd) ? in_md - in_rd : in_rd - in_md;
					dr_q    <= absdiff8(in_rr, in_mr);
					dg_q    <= absdiff8(in_rg, in_mg);
					db_q    <= absdiff8(in_rb, in_mb);
					sumsq_q <= '0;
				end
			end
			ST_SQ: begin
				sumsq_q <= sumsq_next;
				if (chan_q == CH_BLUE) begin
					rad_q  <= RADW'(sumsq_next) << (2 * COLOR_FRAC_BITS);
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			ST_ROOT: begin
				rad_q <= rad_q << 2;
				if (fits) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[RB-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[RB-2:0], 1'b0};
				end
			end
			ST_ACC: begin
				if (last_q && can_emit) begin
					out_dsum_q  <= dsum_next;
					out_csum_q  <= csum_next;
					out_count_q <= count_next;
					out_sat_q   <= ovf_next;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - DSUM_W - CSUM_W - COUNT_W){1'b0}},
	                        out_count_q, out_csum_q, out_dsum_q};
	assign m_axis_tuser  = out_sat_q;

endmodule

`default_nettype wire

[hw/rtl/dcea_checker.sv]
// ----------------------------------------------------------------------------
// dcea_checker
// Port-level checks for the depth and color error accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module dcea_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_axis_tvalid,
	input wire logic                              s_axis_tready,
	input wire logic [dcea_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input wire logic                              m_axis_tuser,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready
);
	import dcea_pkg::*;

	// A result transaction waits until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// The accepted pixel occupies the sequencer for the following cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again right after a transaction");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// With no counted pixel both sums must be zero and the saturated flag clear.
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[90:71] == '0) |->
			(m_axis_tdata[70:0] == '0) && !m_axis_tuser)
		else $error("nonzero sums without counted pixels");

endmodule

bind depth_color_error_accumulator_top dcea_checker u_dcea_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the depth and color error accumulator. Pixel pairs
// go in on the input stream and frame totals are compared, field by field,
// with a behavioral predictor that keeps its own sums, count and range limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import dcea_pkg::*;

	localparam int MAX_PIXELS      = 524288;
	localparam int COLOR_FRAC_BITS = 4;
	// The count field saturates at the smaller of the pixel limit and its own range.
	localparam int COUNT_CAP       = (MAX_PIXELS < (1 << COUNT_W) - 1) ?
	                                 MAX_PIXELS : (1 << COUNT_W) - 1;
	localparam logic [DSUM_W-1:0] DSUM_FULL = '1;
	localparam logic [CSUM_W-1:0] CSUM_FULL = '1;
	// Idle margin after the last result, ample against the busy time of one pixel.
	localparam int DRAIN_CYCLES    = 40;
	localparam int HOLD_CYCLES     = 300;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASE_ITEMS     = 160;

	// One pixel pair as it travels on the input stream.
	typedef struct packed {
		logic [DEPTH_W-1:0] ref_depth;
		logic [DEPTH_W-1:0] meas_depth;
		logic [COLOR_W-1:0] ref_red;
		logic [COLOR_W-1:0] ref_green;
		logic [COLOR_W-1:0] ref_blue;
		logic [COLOR_W-1:0] meas_red;
		logic [COLOR_W-1:0] meas_green;
		logic [COLOR_W-1:0] meas_blue;
		logic               last_pixel;
	} pixel_t;

	// Totals that the block reports at the end of a frame.
	typedef struct packed {
		logic [DSUM_W-1:0]  depth_err;
		logic [CSUM_W-1:0]  color_err;
		logic [COUNT_W-1:0] count;
		logic               saturated;
	} totals_t;

	// One row of the directed table. A row may first rewrite the range limit,
	// and may carry totals worked out by hand instead of the predicted ones.
	typedef struct packed {
		logic               write_range;
		logic [DEPTH_W-1:0] range_mm;
		pixel_t             px;
		logic               typed;
		totals_t            want;
	} stim_row_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
	logic                    s_axis_tlast  = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    m_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [DEPTH_W-1:0]      cfg_data      = '0;
	logic                    cfg_valid     = 1'b0;
	logic                    cfg_ready;

	// Predictor state: the range register and the running frame totals.
	logic [DEPTH_W-1:0]      range_mm      = 16'hFFFF;
	logic [DSUM_W-1:0]       acc_depth     = '0;
	logic [CSUM_W-1:0]       acc_color     = '0;
	logic [COUNT_W-1:0]      acc_count     = '0;
	logic                    acc_flag      = 1'b0;

	// Frame totals still owed by the block, oldest first.
	totals_t                 expected_totals[$];

	int                      mismatches      = 0;
	int                      results_checked = 0;
	int                      pixels_counted  = 0;
	int                      pixels_skipped  = 0;
	int                      range_writes    = 0;
	int                      cycle_count     = 0;
	int                      tx_max_gap      = 5;
	int                      rx_max_gap      = 5;
	bit                      hold_request    = 1'b0;

	depth_color_error_accumulator_top #(
		.MAX_PIXELS     (MAX_PIXELS),
		.COLOR_FRAC_BITS(COLOR_FRAC_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_data     (cfg_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	function automatic logic [31:0] chan_sq(input logic [COLOR_W-1:0] a, b);
		logic [COLOR_W-1:0] d;
		d = (a > b) ? a - b : b - a;
		return 32'(d) * 32'(d);
	endfunction

	// Euclidean RGB distance with COLOR_FRAC_BITS fraction bits, rounded down.
	// The root is found one result bit at a time, largest bit first, keeping a
	// bit whenever its square still fits under the scaled sum of squares.
	function automatic logic [15:0] color_distance(input pixel_t p);
		logic [31:0] scaled;
		logic [15:0] root;
		logic [15:0] trial;
		scaled = (chan_sq(p.ref_red, p.meas_red) + chan_sq(p.ref_green, p.meas_green)
			+ chan_sq(p.ref_blue, p.meas_blue)) << (2 * COLOR_FRAC_BITS);
		root = '0;
		for (int i = 15; i >= 0; i--) begin
			trial = root | (16'd1 << i);
			if (32'(trial) * 32'(trial) <= scaled)
				root = trial;
		end
		return root;
	endfunction

	// Folds one accepted pixel into the running totals. On the last pixel of a
	// frame it hands back the totals and starts the next frame from zero.
	task automatic accumulate_pixel(input pixel_t p, output logic emitted,
			output totals_t t);
		logic [DEPTH_W-1:0] diff;
		logic [63:0]        dsum;
		logic [63:0]        csum;
		emitted = 1'b0;
		t = '0;
		if (p.ref_depth != 0 && p.meas_depth != 0 && p.meas_depth <= range_mm) begin
			diff = (p.meas_depth > p.ref_depth) ? p.meas_depth - p.ref_depth
				: p.ref_depth - p.meas_depth;
			dsum = 64'(acc_depth) + 64'(diff);
			csum = 64'(acc_color) + 64'(color_distance(p));
			// Each sum sticks at all ones on overflow; the other keeps going.
			if (dsum > 64'(DSUM_FULL)) begin
				acc_depth = DSUM_FULL;
				acc_flag = 1'b1;
			end else begin
				acc_depth = dsum[DSUM_W-1:0];
			end
			if (csum > 64'(CSUM_FULL)) begin
				acc_color = CSUM_FULL;
				acc_flag = 1'b1;
			end else begin
				acc_color = csum[CSUM_W-1:0];
			end
			if (acc_count >= COUNT_CAP)
				acc_flag = 1'b1;
			else
				acc_count = acc_count + 1'b1;
			pixels_counted++;
		end else begin
			pixels_skipped++;
		end
		if (p.last_pixel) begin
			emitted = 1'b1;
			t.depth_err = acc_depth;
			t.color_err = acc_color;
			t.count = acc_count;
			t.saturated = acc_flag;
			acc_depth = '0;
			acc_color = '0;
			acc_count = '0;
			acc_flag = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Offers one pixel after a random gap and waits for the transaction. With
	// no gap, tvalid simply stays high and only the payload changes.
	task automatic send_pixel(input pixel_t p, input logic typed, input totals_t want);
		int      gap;
		logic    emitted;
		totals_t predicted;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p.meas_blue, p.meas_green, p.meas_red, p.ref_blue,
			p.ref_green, p.ref_red, p.meas_depth, p.ref_depth};
		s_axis_tlast <= p.last_pixel;
		do @(posedge clk); while (!s_axis_tready);
		accumulate_pixel(p, emitted, predicted);
		if (emitted) begin
			if (typed)
				expected_totals = {expected_totals, want};
			else
				expected_totals = {expected_totals, predicted};
		end
	endtask

	// The range limit may only change while the block is idle. A pixel that
	// ends no frame leaves nothing to wait for, so after the last result the
	// bench still gives the block time to finish any pixel in flight.
	task automatic await_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_totals.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_range(input logic [DEPTH_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		range_mm = v;
		range_writes++;
	endtask

	// Random pixel pair. Depths are biased toward the validity edges: missing
	// data, the range limit and one past it, and full scale. Most pixels fall
	// inside the limit so that frames carry real sums.
	function automatic pixel_t random_pixel(input logic [DEPTH_W-1:0] rng,
			input logic last);
		pixel_t p;
		case ($urandom_range(0, 9))
			0: p.ref_depth = '0;
			1: p.ref_depth = '1;
			default: p.ref_depth = 16'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: p.meas_depth = '0;
			1: p.meas_depth = rng;
			2: p.meas_depth = rng + 16'd1;
			3: p.meas_depth = '1;
			default: p.meas_depth = (rng == 0) ? 16'($urandom)
				: 16'($urandom_range(1, rng));
		endcase
		{p.ref_red, p.ref_green, p.ref_blue} = 24'($urandom);
		if ($urandom_range(0, 7) == 0)
			{p.meas_red, p.meas_green, p.meas_blue} = {p.ref_red, p.ref_green, p.ref_blue};
		else
			{p.meas_red, p.meas_green, p.meas_blue} = 24'($urandom);
		p.last_pixel = last;
		return p;
	endfunction

	// Builds a directed row; colors are given as 24'hRRGGBB.
	function automatic stim_row_t drow(input logic wr, input logic [DEPTH_W-1:0] rng,
			input logic [DEPTH_W-1:0] rd, md, input logic [23:0] rc, mc,
			input logic last, typed, input logic [DSUM_W-1:0] de,
			input logic [CSUM_W-1:0] ce, input logic [COUNT_W-1:0] cnt);
		stim_row_t r;
		r.write_range = wr;
		r.range_mm = rng;
		r.px.ref_depth = rd;
		r.px.meas_depth = md;
		{r.px.ref_red, r.px.ref_green, r.px.ref_blue} = rc;
		{r.px.meas_red, r.px.meas_green, r.px.meas_blue} = mc;
		r.px.last_pixel = last;
		r.typed = typed;
		r.want.depth_err = de;
		r.want.color_err = ce;
		r.want.count = cnt;
		r.want.saturated = 1'b0;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Output side: random back-pressure and the result checker
	// ------------------------------------------------------------------------

	// The receiver draws a stall before every result. Once, on request, it
	// holds tready low for a long stretch so that a finished frame sits in the
	// output register and the next last pixel stalls the input stream.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, rx_max_gap);
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic check_field(input string name, input logic [63:0] want, got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Every output transaction is matched against the oldest expected totals.
	always @(posedge clk) begin : result_check
		totals_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_totals.size() == 0) begin
				$display("%0t: frame result arrived with none expected, tdata %h",
					$time, m_axis_tdata);
				mismatches++;
			end else begin
				want = expected_totals.pop_front();
				check_field("depth_error_sum", 64'(want.depth_err),
					64'(m_axis_tdata[DSUM_W-1:0]));
				check_field("color_error_sum", 64'(want.color_err),
					64'(m_axis_tdata[DSUM_W+CSUM_W-1:DSUM_W]));
				check_field("pixel_count", 64'(want.count),
					64'(m_axis_tdata[DSUM_W+CSUM_W+COUNT_W-1:DSUM_W+CSUM_W]));
				check_field("saturated", 64'(want.saturated), 64'(m_axis_tuser));
				results_checked++;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, expected_totals.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin
		stim_row_t directed[$];
		int        sent;
		int        len;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Single-pixel frames whose totals follow at a glance
		// carry them typed in; the rest rely on the predictor.
		// Counted pixel with identical colors: pure depth error.
		directed = {directed,
			drow(0, 0, 1000, 1500, 24'h102030, 24'h102030, 1, 1, 500, 0, 1)};
		// Missing reference depth, then missing measured depth: nothing counts.
		directed = {directed,
			drow(0, 0, 0, 500, 24'h000000, 24'hFFFFFF, 1, 1, 0, 0, 0)};
		directed = {directed,
			drow(0, 0, 500, 0, 24'hFFFFFF, 24'h000000, 1, 1, 0, 0, 0)};
		// Full-scale depth gap and largest color distance, both directions.
		// sqrt(3 * 255^2) * 16 rounds down to 7066.
		directed = {directed, drow(0, 0, 16'hFFFF, 1, 24'h000000, 24'hFFFFFF, 1, 1,
			65534, 7066, 1)};
		directed = {directed, drow(0, 0, 1, 16'hFFFF, 24'hFFFFFF, 24'h000000, 1, 1,
			65534, 7066, 1)};
		// A 3-4-5 color triangle gives an exact distance of 5.
		directed = {directed,
			drow(0, 0, 100, 100, 24'h000000, 24'h030400, 1, 1, 0, 80, 1)};
		// A three-pixel frame.
		directed = {directed,
			drow(0, 0, 1200, 1180, 24'h804020, 24'h7F4521, 0, 0, 0, 0, 0)};
		directed = {directed,
			drow(0, 0, 3000, 3500, 24'h00FF00, 24'hFF00FF, 0, 0, 0, 0, 0)};
		directed = {directed,
			drow(0, 0, 70, 65000, 24'h123456, 24'h654321, 1, 0, 0, 0, 0)};
		// A frame whose last pixel is rejected still reports what came before.
		directed = {directed,
			drow(0, 0, 2000, 2100, 24'h0A0B0C, 24'h0C0B0A, 0, 0, 0, 0, 0)};
		directed = {directed,
			drow(0, 0, 0, 2100, 24'hFFFFFF, 24'hFFFFFF, 1, 0, 0, 0, 0)};
		// Range limit of 1000: exactly at the limit counts, one above does not.
		directed = {directed, drow(1, 1000, 500, 1000, 24'h505050, 24'h505050, 1, 1,
			500, 0, 1)};
		directed = {directed,
			drow(0, 0, 500, 1001, 24'h000000, 24'hFFFFFF, 1, 1, 0, 0, 0)};
		// Range limit of zero rejects every nonzero measured depth.
		directed = {directed,
			drow(1, 0, 5, 5, 24'h000000, 24'h000000, 1, 1, 0, 0, 0)};
		directed = {directed,
			drow(0, 0, 16'hFFFF, 1, 24'hFFFFFF, 24'h000000, 1, 1, 0, 0, 0)};
		// Back to full range with alternating bit patterns on every field.
		directed = {directed, drow(1, 16'hFFFF, 16'hAAAA, 16'h5555, 24'hAAAAAA,
			24'h555555, 0, 0, 0, 0, 0)};
		directed = {directed, drow(0, 0, 16'h5555, 16'hAAAA, 24'h555555, 24'hAAAAAA,
			1, 0, 0, 0, 0)};

		foreach (directed[i]) begin
			if (directed[i].write_range) begin
				await_idle();
				write_range(directed[i].range_mm);
			end
			send_pixel(directed[i].px, directed[i].typed, directed[i].want);
		end

		// Random frames in several range settings. Most frames are short; one
		// in ten runs to a few dozen pixels. Phase 3 also asks the receiver for
		// its long hold-off, and phase 4 runs both sides without idling.
		for (int ph = 0; ph < 6; ph++) begin
			await_idle();
			case (ph)
				0: write_range(16'hFFFF);
				1: write_range(16'd1);
				2: write_range(16'd2500);
				3: write_range(16'($urandom));
				4: write_range(16'h8000);
				default: write_range(16'hFFFF);
			endcase
			tx_max_gap = (ph == 4) ? 0 : 5;
			rx_max_gap = (ph == 4) ? 0 : 5;
			if (ph == 3)
				hold_request = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					send_pixel(random_pixel(range_mm, k == len - 1), 1'b0, '0);
					sent++;
				end
			end
		end

		// Drain: every frame must have reported, then let the pipeline settle.
		await_idle();

		$display("Checked %0d frame results over %0d pixels, %0d counted and %0d rejected.",
			results_checked, pixels_counted + pixels_skipped, pixels_counted,
			pixels_skipped);
		$display("Range limit written %0d times including both extremes, with %0s.",
			range_writes, "one long output hold-off that stalled the input");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

[depth_color_error_accumulator_top.f]
hw/rtl/dcea_pkg.sv
hw/rtl/depth_color_error_accumulator_top.sv
hw/rtl/dcea_checker.sv
bench/tb.sv
